// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge out of reset
`define ASSERT_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/npafz_pkg.sv =====
// package: microcode program, control word type and constants for the prime search
package npafz_pkg;

    localparam int LIMIT_W = 15;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd32000;

    localparam int PC_W = 5;
    localparam int OP_W = 4;
    localparam int COND_W = 4;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
    localparam logic [OP_W-1:0] OP_INIT_D    = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV_START = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV_STEP  = 4'd4;
    localparam logic [OP_W-1:0] OP_STEP_D    = 4'd5;
    localparam logic [OP_W-1:0] OP_RES_CAND  = 4'd6;
    localparam logic [OP_W-1:0] OP_RES_PRIME = 4'd7;
    localparam logic [OP_W-1:0] OP_RES_RAW   = 4'd8;
    localparam logic [OP_W-1:0] OP_RES_TWO   = 4'd9;
    localparam logic [OP_W-1:0] OP_NEXT_CAND = 4'd10;
    localparam logic [OP_W-1:0] OP_PUSH      = 4'd11;

    // jump conditions
    localparam logic [COND_W-1:0] C_NEVER    = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS   = 4'd1;
    localparam logic [COND_W-1:0] C_NO_IN    = 4'd2;
    localparam logic [COND_W-1:0] C_ZERO     = 4'd3;
    localparam logic [COND_W-1:0] C_LT2      = 4'd4;
    localparam logic [COND_W-1:0] C_LT4      = 4'd5;
    localparam logic [COND_W-1:0] C_EVEN     = 4'd6;
    localparam logic [COND_W-1:0] C_SQ_GT    = 4'd7;
    localparam logic [COND_W-1:0] C_DIV_MORE = 4'd8;
    localparam logic [COND_W-1:0] C_REM_ZERO = 4'd9;
    localparam logic [COND_W-1:0] C_FIRST    = 4'd10;
    localparam logic [COND_W-1:0] C_OVER     = 4'd11;
    localparam logic [COND_W-1:0] C_OUT_BUSY = 4'd12;

    // program step addresses
    localparam logic [PC_W-1:0] S_WAIT     = 5'd0;
    localparam logic [PC_W-1:0] S_ZCHK     = 5'd1;
    localparam logic [PC_W-1:0] S_TEST     = 5'd2;
    localparam logic [PC_W-1:0] S_LT4      = 5'd3;
    localparam logic [PC_W-1:0] S_EVEN     = 5'd4;
    localparam logic [PC_W-1:0] S_LOOP     = 5'd5;
    localparam logic [PC_W-1:0] S_DSTART   = 5'd6;
    localparam logic [PC_W-1:0] S_DIV      = 5'd7;
    localparam logic [PC_W-1:0] S_REMCHK   = 5'd8;
    localparam logic [PC_W-1:0] S_STEP     = 5'd9;
    localparam logic [PC_W-1:0] S_PRIME    = 5'd10;
    localparam logic [PC_W-1:0] S_FOUND    = 5'd11;
    localparam logic [PC_W-1:0] S_PASS     = 5'd12;
    localparam logic [PC_W-1:0] S_NEXT     = 5'd13;
    localparam logic [PC_W-1:0] S_LIMCHK   = 5'd14;
    localparam logic [PC_W-1:0] S_RETEST   = 5'd15;
    localparam logic [PC_W-1:0] S_GIVEUP   = 5'd16;
    localparam logic [PC_W-1:0] S_TWO      = 5'd17;
    localparam logic [PC_W-1:0] S_OUT      = 5'd18;
    localparam logic [PC_W-1:0] S_RET      = 5'd19;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } ucode_t;

    // control store
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{op: OP_NONE, cond: C_ALWAYS, target: S_WAIT};
        case (pc)
            S_WAIT:   w = '{op: OP_LOAD,      cond: C_NO_IN,    target: S_WAIT};
            S_ZCHK:   w = '{op: OP_NONE,      cond: C_ZERO,     target: S_TWO};
            S_TEST:   w = '{op: OP_NONE,      cond: C_LT2,      target: S_NEXT};
            S_LT4:    w = '{op: OP_NONE,      cond: C_LT4,      target: S_PRIME};
            S_EVEN:   w = '{op: OP_INIT_D,    cond: C_EVEN,     target: S_NEXT};
            S_LOOP:   w = '{op: OP_NONE,      cond: C_SQ_GT,    target: S_PRIME};
            S_DSTART: w = '{op: OP_DIV_START, cond: C_NEVER,    target: S_WAIT};
            S_DIV:    w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE, target: S_DIV};
            S_REMCHK: w = '{op: OP_NONE,      cond: C_REM_ZERO, target: S_NEXT};
            S_STEP:   w = '{op: OP_STEP_D,    cond: C_ALWAYS,   target: S_LOOP};
            S_PRIME:  w = '{op: OP_NONE,      cond: C_FIRST,    target: S_PASS};
            S_FOUND:  w = '{op: OP_RES_CAND,  cond: C_ALWAYS,   target: S_OUT};
            S_PASS:   w = '{op: OP_RES_PRIME, cond: C_ALWAYS,   target: S_OUT};
            S_NEXT:   w = '{op: OP_NEXT_CAND, cond: C_NEVER,    target: S_WAIT};
            S_LIMCHK: w = '{op: OP_NONE,      cond: C_OVER,     target: S_GIVEUP};
            S_RETEST: w = '{op: OP_NONE,      cond: C_ALWAYS,   target: S_TEST};
            S_GIVEUP: w = '{op: OP_RES_RAW,   cond: C_ALWAYS,   target: S_OUT};
            S_TWO:    w = '{op: OP_RES_TWO,   cond: C_ALWAYS,   target: S_OUT};
            S_OUT:    w = '{op: OP_PUSH,      cond: C_OUT_BUSY, target: S_OUT};
            S_RET:    w = '{op: OP_NONE,      cond: C_ALWAYS,   target: S_WAIT};
            default:  w = '{op: OP_NONE,      cond: C_ALWAYS,   target: S_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== src/nearest_prime_away_from_zero.sv =====
// top level: microcoded trial-division search for the nearest prime away from zero
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------
//  in       | in_valid / in_stall       | value_in
//  out      | out_valid / out_stall     | value_out, was_prime
//  config   | magnitude_limit_we        | magnitude_limit
//
// one item at a time; a transfer is taken only at the wait step of the program
// each trial divisor runs a restoring divider, one bit a cycle
// each candidate is tried with odd divisors from 3 up to its square root
// asynchronous active-low reset: program at wait step, output empty, limit 32000
// a held result waits in the output register while the next input is taken
`include "assert_macros.svh"

module nearest_prime_away_from_zero
    import npafz_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          magnitude_limit_we,
    input  logic [LIMIT_W-1:0]            magnitude_limit,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] value_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] value_out,
    output logic                          was_prime
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int SQ_W  = VALUE_WIDTH + 2;

    logic [PC_W-1:0]        pc_reg;
    logic [PC_W-1:0]        pc_next;
    ucode_t                 uw;
    logic                   cond_true;

    logic [LIMIT_W-1:0]     limit_reg;
    logic [VALUE_WIDTH-1:0] raw_reg;
    logic                   neg_reg;
    logic                   first_reg;
    logic [VALUE_WIDTH-1:0] cand_reg;
    logic [VALUE_WIDTH-1:0] d_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [VALUE_WIDTH-1:0] res_value_reg;
    logic                   res_prime_reg;
    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] value_out_reg;
    logic                   was_prime_reg;

    logic [VALUE_WIDTH-1:0] in_raw;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic [VALUE_WIDTH:0]   trial;
    logic                   trial_ge;
    logic [VALUE_WIDTH-1:0] rem_next;
    logic                   out_busy;
    logic                   push;
    logic                   over_limit;

    assign uw        = ucode_rom(pc_reg);
    assign in_stall  = (pc_reg != S_WAIT);
    assign out_busy  = out_valid_reg && out_stall;
    assign push      = (uw.op == OP_PUSH) && !out_busy;
    assign in_raw    = value_in;
    assign in_mag    = value_in[VALUE_WIDTH-1] ? (~in_raw + 1'b1) : in_raw;

    assign over_limit = {{LIMIT_W{1'b0}}, cand_reg} > {{VALUE_WIDTH{1'b0}}, limit_reg};

    // one restoring division step
    assign trial    = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign trial_ge = trial >= {1'b0, d_reg};
    assign rem_next = trial_ge ? VALUE_WIDTH'(trial - {1'b0, d_reg})
                               : trial[VALUE_WIDTH-1:0];

    always_comb
    begin
        case (uw.cond)
            C_NEVER:    cond_true = 1'b0;
            C_ALWAYS:   cond_true = 1'b1;
            C_NO_IN:    cond_true = !in_valid;
            C_ZERO:     cond_true = (raw_reg == '0);
            C_LT2:      cond_true = (cand_reg < VALUE_WIDTH'(2));
            C_LT4:      cond_true = (cand_reg < VALUE_WIDTH'(4));
            C_EVEN:     cond_true = !cand_reg[0];
            C_SQ_GT:    cond_true = (sq_reg > {2'b00, cand_reg});
            C_DIV_MORE: cond_true = (cnt_reg != CNT_W'(1));
            C_REM_ZERO: cond_true = (rem_reg == '0);
            C_FIRST:    cond_true = first_reg;
            C_OVER:     cond_true = over_limit;
            C_OUT_BUSY: cond_true = out_busy;
            default:    cond_true = 1'b0;
        endcase
    end

    assign pc_next = cond_true ? uw.target : (pc_reg + 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (magnitude_limit_we)
        begin
            limit_reg <= magnitude_limit;
        end
    end

    // datapath driven by the control word
    always_ff @(posedge clk)
    begin
        case (uw.op)
            OP_LOAD:
            begin
                if (in_valid)
                begin
                    raw_reg   <= in_raw;
                    neg_reg   <= value_in[VALUE_WIDTH-1];
                    cand_reg  <= in_mag;
                    first_reg <= 1'b1;
                end
            end
            OP_INIT_D:
            begin
                d_reg  <= VALUE_WIDTH'(3);
                sq_reg <= SQ_W'(9);
            end
            OP_DIV_START:
            begin
                rem_reg <= '0;
                quo_reg <= cand_reg;
                cnt_reg <= CNT_W'(VALUE_WIDTH);
            end
            OP_DIV_STEP:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_reg << 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            OP_STEP_D:
            begin
                d_reg  <= d_reg + VALUE_WIDTH'(2);
                sq_reg <= sq_reg + ((SQ_W'(d_reg) + SQ_W'(1)) << 2);
            end
            OP_RES_CAND:
            begin
                res_value_reg <= neg_reg ? (~cand_reg + 1'b1) : cand_reg;
                res_prime_reg <= 1'b0;
            end
            OP_RES_PRIME:
            begin
                res_value_reg <= raw_reg;
                res_prime_reg <= 1'b1;
            end
            OP_RES_RAW:
            begin
                res_value_reg <= raw_reg;
                res_prime_reg <= 1'b0;
            end
            OP_RES_TWO:
            begin
                res_value_reg <= VALUE_WIDTH'(2);
                res_prime_reg <= 1'b0;
            end
            OP_NEXT_CAND:
            begin
                cand_reg  <= cand_reg + 1'b1;
                first_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            value_out_reg <= res_value_reg;
            was_prime_reg <= res_prime_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value_out = value_out_reg;
    assign was_prime = was_prime_reg;

    `ASSERT_NEXT(a_out_from_push, pc_reg == S_OUT && !out_busy, out_valid_reg,
        "result step did not fill the output register")
    `ASSERT_IMPLY(a_div_count, pc_reg == S_DIV, cnt_reg != '0,
        "divider stepped with no bits left")
    `ASSERT_IMPLY(a_rem_below_d, pc_reg == S_REMCHK, rem_reg < d_reg,
        "remainder not below divisor after division")
    `ASSERT_IMPLY(a_giveup_over, pc_reg == S_GIVEUP, over_limit,
        "search gave up with candidate within the limit")

endmodule

// ===== sim/tb.sv =====
// testbench for nearest_prime_away_from_zero: queued stimulus, expected-result check per transfer
`timescale 1ns / 100ps

module tb
    import npafz_pkg::*;
();

    localparam int VW = 16;
    localparam int QUIET_LIMIT = 1000000;
    localparam int IDLE_PERCENT = 12;

    typedef struct packed {
        logic signed [VW-1:0] value;
        logic                 prime;
    } prime_result_t;

    localparam logic signed [VW-1:0] CORNER_VALUES [23] = '{
        0, 1, -1, 2, -2, 3, -3, 4, -4, 9, -9, 25, 97, -97, 100, -100,
        31990, 32000, -32000, 32749, -32749, 32767, -32768
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 magnitude_limit_we = 1'b0;
    logic [LIMIT_W-1:0]   magnitude_limit = LIMIT_RESET;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic signed [VW-1:0] value_in = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [VW-1:0] value_out;
    logic                 was_prime;

    logic signed [VW-1:0] pending_values [$];
    prime_result_t        expected_results [$];
    logic [LIMIT_W-1:0]   limit_setting = LIMIT_RESET;
    int                   values_sent = 0;
    int                   results_seen = 0;
    int                   mismatch_count = 0;
    int                   quiet_cycles = 0;
    int                   limit_settings = 1;
    logic                 calm;

    nearest_prime_away_from_zero #(
        .VALUE_WIDTH(VW)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .magnitude_limit_we(magnitude_limit_we),
        .magnitude_limit(magnitude_limit),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .value_in(value_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .value_out(value_out),
        .was_prime(was_prime)
    );

    always #1 clk = ~clk;

    // no idling on either side for a stretch in the middle of the run
    assign calm = (values_sent >= 40) && (values_sent < 70);

    function automatic bit magnitude_is_prime(input int unsigned m);
        int unsigned d;
        if (m < 2)
            return 1'b0;
        if (m < 4)
            return 1'b1;
        if (m % 2 == 0)
            return 1'b0;
        for (d = 3; d * d <= m; d += 2)
            if (m % d == 0)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic prime_result_t predict_replacement(input logic signed [VW-1:0] v,
                                                          input logic [LIMIT_W-1:0] limit);
        prime_result_t r;
        int            sv;
        int unsigned   mag;
        int unsigned   cand;
        sv = v;
        mag = (sv < 0) ? -sv : sv;
        r.value = v;
        r.prime = 1'b0;
        if (sv == 0)
            r.value = VW'(2);
        else if (magnitude_is_prime(mag))
            r.prime = 1'b1;
        else
        begin
            cand = mag;
            while (cand <= limit && !magnitude_is_prime(cand))
                cand++;
            if (cand <= limit)
                r.value = (sv < 0) ? VW'(-int'(cand)) : VW'(cand);
        end
        return r;
    endfunction

    function automatic logic signed [VW-1:0] pick_value();
        int kind;
        int mag;
        kind = $urandom_range(0, 99);
        if (kind < 12)
            return VW'($urandom);
        if (kind < 20)
            return $urandom_range(0, 1) ? VW'(16'sh8000 + $urandom_range(0, 60))
                                        : VW'(16'sh7fff - $urandom_range(0, 60));
        if (kind < 32)
            mag = $urandom_range(0, 4);
        else
            mag = $urandom_range(0, 2000);
        return $urandom_range(0, 1) ? VW'(-mag) : VW'(mag);
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        $display("mismatch on result %0d: %s", results_seen, what);
    endtask

    task automatic queue_random(input int count);
        @(negedge clk);
        repeat (count)
            pending_values.push_back(pick_value());
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_values.size() != 0 || expected_results.size() != 0 || in_valid);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        @(posedge clk);
        magnitude_limit_we <= 1'b1;
        magnitude_limit <= v;
        @(posedge clk);
        magnitude_limit_we <= 1'b0;
        limit_setting = v;
        limit_settings++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value_in <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(predict_replacement(value_in, limit_setting));
                values_sent <= values_sent + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_values.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    in_valid <= 1'b1;
                    value_in <= pending_values.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        prime_result_t exp_r;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    note_mismatch($sformatf("unexpected transfer, value_out %0d", value_out));
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (value_out !== exp_r.value)
                        note_mismatch($sformatf("value_out %0d, expected %0d",
                                                value_out, exp_r.value));
                    if (was_prime !== exp_r.prime)
                        note_mismatch($sformatf("was_prime %b, expected %b",
                                                was_prime, exp_r.prime));
                end
            end
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (CORNER_VALUES[i])
            pending_values.push_back(CORNER_VALUES[i]);
        queue_random(18);
        wait_idle();

        write_limit(15'h7fff);
        queue_random(16);
        wait_idle();

        write_limit(15'd2);
        queue_random(10);
        wait_idle();

        write_limit(15'd0);
        queue_random(8);
        pending_values.push_back('0);
        pending_values.push_back(VW'(1));
        wait_idle();

        write_limit(15'd1);
        queue_random(8);
        pending_values.push_back(VW'(-1));
        wait_idle();

        write_limit(LIMIT_W'($urandom_range(2, 3000)));
        queue_random(20);
        wait_idle();

        write_limit(LIMIT_RESET);
        queue_random(20);
        wait_idle();

        repeat (40) @(posedge clk);
        if (expected_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        $display("%0d values sent, %0d results compared, %0d limit settings from 0 to 32767",
                 values_sent, results_seen, limit_settings);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
